>>> rtl/core/mced_pkg.sv
`default_nettype none
package mced_pkg;
   localparam int FLOORS = 16;
   localparam int CARS = 4;
   localparam int FW = 4;
   localparam int CW = 2;

   localparam logic [1:0] DIR_UP = 2'd0;
   localparam logic [1:0] DIR_DN = 2'd1;
   localparam logic [1:0] DIR_STOP = 2'd2;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_CALL = 2'd1;
   localparam logic [1:0] OP_DEST = 2'd2;

   // One car's view in the decide step.
   typedef struct packed {
      logic [FW-1:0] floor;
      logic [1:0]    dir;
   } car_pos_type;

   // Summary of a car's floor scan, handed from the scanner to the sequencer.
   typedef struct packed {
      logic          dest_above;
      logic          dest_below;
      logic          req_above;
      logic          req_below;
      logic [FW:0]   n_above;
      logic [FW:0]   n_below;
      logic [FW-1:0] near_hi;
      logic [FW-1:0] near_lo;
   } scan_type;
endpackage
`default_nettype wire

>>> rtl/core/multi_car_elevator_dispatch_core.sv
`default_nettype none
// Elevator dispatch core for several cars sharing one set of hall calls.
// Input words arrive on the req_ channel: a hall call or a car destination
// updates state and produces no output. A tick runs the dispatch pass. Each
// car in order counts down its door timers in the timer step, then the stop
// check looks at its own floor. If it stops there, it goes straight to the
// hand-off to the next car; else its floors are scanned one per cycle by a
// shared scanner, then the rule check decides if it can, and otherwise the
// car compares itself against the other cars, one car per cycle, before the
// hand-off. After all cars have decided, every car with idle doors that is
// heading up or down moves one floor, if not at the end of the shaft. The
// core then emits one status word per car on the rsp_ channel, at most one
// per cycle, with rsp_tlast on the last car. req_tready is low from the tick
// until the last status word is loaded. If the receiver stalls, the current
// status word holds in its register until taken.
// Synchronous reset clears all calls, destinations and timers, parks every
// car stopped at floor zero and sets the door time to three.
// csr_ writes set the door time at once; issue them only while no word is
// in flight.
module multi_car_elevator_dispatch_core
   import mced_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata bits: opcode[1:0], floor[5:2], call_down[6], car[8:7], zero pad
   input  wire logic [15:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata bits: car_index[1:0], car_floor[5:2], car_direction[7:6],
   // loading_left[11:8], unloading_left[15:12], destinations[31:16]
   output logic [31:0]      rsp_tdata,
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [3:0]  csr_wdata
);
   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_PREP  = 8'b0000_0010,
      S_TOP   = 8'b0000_0100,
      S_SCAN  = 8'b0000_1000,
      S_RULE  = 8'b0001_0000,
      S_PEER  = 8'b0010_0000,
      S_FINAL = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   state_type         st_ff, st_in;
   logic [3:0]        door_ff, door_in;
   logic [FLOORS-1:0] up_ff, up_in, dn_ff, dn_in;
   logic [FW-1:0]     fl_ff [CARS], fl_in [CARS];
   logic [1:0]        dir_ff [CARS], dir_in [CARS];
   logic [FLOORS-1:0] dst_ff [CARS], dst_in [CARS];
   logic [3:0]        ld_ff [CARS], ld_in [CARS];
   logic [3:0]        ul_ff [CARS], ul_in [CARS];
   logic [CW-1:0]     c_ff, c_in, j_ff, j_in;
   logic              bu_ff, bu_in, bd_ff, bd_in, ou_ff, ou_in, od_ff, od_in;
   logic [FW:0]       cu_ff, cu_in, cd_ff, cd_in;
   scan_type          sc_ff, sc_in;
   logic              scan_start, scan_done;
   scan_type          scan_res;
   logic              rv_ff, rv_in;
   logic [31:0]       rd_ff, rd_in;
   logic              rl_ff, rl_in;

   logic [1:0]    op;
   logic [FW-1:0] rfl;
   logic          rdown;
   logic [CW-1:0] rcar;
   logic [FW-1:0] cur;
   logic [1:0]    dir;
   logic [FW-1:0] of;
   logic [1:0]    odr;
   logic          same_ahead, upish, dnish, mupish, mdnish;

   assign op = req_tdata[1:0];
   assign rfl = req_tdata[5:2];
   assign rdown = req_tdata[6];
   assign rcar = req_tdata[8:7];
   assign cur = fl_ff[c_ff];
   assign dir = dir_ff[c_ff];
   assign of = fl_ff[j_ff];
   assign odr = dir_ff[j_ff];
   assign same_ahead = (of == cur) && (j_ff < c_ff);
   assign upish = (odr == DIR_UP) || (odr == DIR_STOP);
   assign dnish = (odr == DIR_DN) || (odr == DIR_STOP);
   assign mupish = (dir == DIR_UP) || (dir == DIR_STOP);
   assign mdnish = (dir == DIR_DN) || (dir == DIR_STOP);

   assign req_tready = (st_ff == S_IDLE);
   assign scan_start = (st_ff == S_TOP) && (st_in == S_SCAN);

   mced_scan u_scan (
      .clock (clock),
      .start (scan_start),
      .cur   (cur),
      .dest  (dst_ff[c_ff]),
      .calls (up_ff | dn_ff),
      .done  (scan_done),
      .res   (scan_res)
   );

   always_comb begin
      st_in = st_ff;
      door_in = csr_we ? csr_wdata : door_ff;
      up_in = up_ff;
      dn_in = dn_ff;
      fl_in = fl_ff;
      dir_in = dir_ff;
      dst_in = dst_ff;
      ld_in = ld_ff;
      ul_in = ul_ff;
      c_in = c_ff;
      j_in = j_ff;
      bu_in = bu_ff; bd_in = bd_ff; ou_in = ou_ff; od_in = od_ff;
      cu_in = cu_ff; cd_in = cd_ff;
      sc_in = sc_ff;
      rv_in = rv_ff;
      rd_in = rd_ff;
      rl_in = rl_ff;
      case (st_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               case (op)
                  OP_CALL: begin
                     if (rdown) dn_in[rfl] = 1'b1;
                     else up_in[rfl] = 1'b1;
                  end
                  OP_DEST: begin
                     if (rfl != fl_ff[rcar]) begin
                        if (dir_ff[rcar] == DIR_STOP)
                           dir_in[rcar] = (rfl < fl_ff[rcar]) ? DIR_DN : DIR_UP;
                        dst_in[rcar][rfl] = 1'b1;
                     end
                  end
                  OP_TICK: begin
                     c_in = '0;
                     st_in = S_PREP;
                  end
                  default: ;
               endcase
            end
         end
         S_PREP: begin
            // Count timers down and clamp a direction that points off the shaft.
            if (ld_ff[c_ff] != 4'd0) ld_in[c_ff] = ld_ff[c_ff] - 4'd1;
            if (ul_ff[c_ff] != 4'd0) ul_in[c_ff] = ul_ff[c_ff] - 4'd1;
            if ((cur == FW'(FLOORS - 1) && dir == DIR_UP) ||
                (cur == '0 && dir == DIR_DN))
               dir_in[c_ff] = DIR_STOP;
            st_in = S_TOP;
         end
         S_TOP: begin
            st_in = S_SCAN;
            if (dst_ff[c_ff][cur]) begin
               dst_in[c_ff][cur] = 1'b0;
               if (ul_ff[c_ff] == 4'd0) ul_in[c_ff] = door_ff;
               st_in = S_FINAL;
            end else if (up_ff[cur] && dir != DIR_DN) begin
               dir_in[c_ff] = DIR_UP;
               up_in[cur] = 1'b0;
               if (ld_ff[c_ff] == 4'd0) ld_in[c_ff] = door_ff;
               st_in = S_FINAL;
            end else if (dn_ff[cur] && dir != DIR_UP) begin
               dir_in[c_ff] = DIR_DN;
               dn_in[cur] = 1'b0;
               if (ld_ff[c_ff] == 4'd0) ld_in[c_ff] = door_ff;
               st_in = S_FINAL;
            end
         end
         S_SCAN: begin
            if (scan_done) begin
               sc_in = scan_res;
               st_in = S_RULE;
            end
         end
         S_RULE: begin
            j_in = '0;
            bu_in = 1'b0; bd_in = 1'b0; ou_in = 1'b0; od_in = 1'b0;
            cu_in = '0; cd_in = '0;
            if (!sc_ff.dest_above && !sc_ff.req_above &&
                !sc_ff.dest_below && !sc_ff.req_below) begin
               dir_in[c_ff] = DIR_STOP;
               st_in = S_FINAL;
            end else if (sc_ff.dest_above && mupish) begin
               dir_in[c_ff] = DIR_UP;
               st_in = S_FINAL;
            end else if (sc_ff.dest_below && mdnish) begin
               dir_in[c_ff] = DIR_DN;
               st_in = S_FINAL;
            end else begin
               st_in = S_PEER;
            end
         end
         S_PEER: begin
            // One peer car per cycle.
            if (j_ff != c_ff) begin
               if (upish && sc_ff.req_above) begin
                  if ((of > cur && of <= sc_ff.near_hi) || same_ahead) bu_in = 1'b1;
                  if (of > cur || same_ahead) cu_in = cu_in + 1'b1;
               end
               if (dnish && sc_ff.req_below) begin
                  if ((of < cur && of >= sc_ff.near_lo) || same_ahead) bd_in = 1'b1;
                  if (of < cur || same_ahead) cd_in = cd_in + 1'b1;
               end
               if (upish && sc_ff.req_below && sc_ff.near_lo >= of &&
                   (sc_ff.near_lo - of) < (cur - sc_ff.near_lo)) begin
                  ou_in = 1'b1;
                  cd_in = cd_in + 1'b1;
               end
               if (dnish && sc_ff.req_above && of >= sc_ff.near_hi &&
                   (of - sc_ff.near_hi) < (sc_ff.near_hi - cur)) begin
                  od_in = 1'b1;
                  cu_in = cu_in + 1'b1;
               end
            end
            j_in = j_ff + 1'b1;
            if (j_ff == CW'(CARS - 1)) begin
               if (mupish && sc_ff.req_above && !bu_in && !od_in)
                  dir_in[c_ff] = DIR_UP;
               else if (mdnish && sc_ff.req_below && !bd_in && !ou_in)
                  dir_in[c_ff] = DIR_DN;
               else if (mupish && sc_ff.req_above && cu_in < sc_ff.n_above)
                  dir_in[c_ff] = DIR_UP;
               else if (mdnish && sc_ff.req_below && cd_in < sc_ff.n_below)
                  dir_in[c_ff] = DIR_DN;
               else
                  dir_in[c_ff] = DIR_STOP;
               st_in = S_FINAL;
            end
         end
         S_FINAL: begin
            if (c_ff == CW'(CARS - 1)) begin
               for (int k = 0; k < CARS; k++) begin
                  if (ld_ff[k] == 4'd0 && ul_ff[k] == 4'd0) begin
                     if (dir_ff[k] == DIR_UP && fl_ff[k] != FW'(FLOORS - 1))
                        fl_in[k] = fl_ff[k] + 1'b1;
                     else if (dir_ff[k] == DIR_DN && fl_ff[k] != '0)
                        fl_in[k] = fl_ff[k] - 1'b1;
                  end
               end
               c_in = '0;
               st_in = S_OUT;
            end else begin
               c_in = c_ff + 1'b1;
               st_in = S_PREP;
            end
         end
         S_OUT: begin
            if (!rv_ff || rsp_tready) begin
               rv_in = 1'b1;
               rd_in = {dst_ff[c_ff], ul_ff[c_ff], ld_ff[c_ff], dir_ff[c_ff],
                        fl_ff[c_ff], c_ff};
               rl_in = (c_ff == CW'(CARS - 1));
               c_in = c_ff + 1'b1;
               if (c_ff == CW'(CARS - 1)) st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
      if (rv_ff && rsp_tready && st_ff != S_OUT) rv_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         door_ff <= 4'd3;
         up_ff <= '0;
         dn_ff <= '0;
         for (int k = 0; k < CARS; k++) begin
            fl_ff[k] <= '0;
            dir_ff[k] <= DIR_STOP;
            dst_ff[k] <= '0;
            ld_ff[k] <= '0;
            ul_ff[k] <= '0;
         end
         c_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         door_ff <= door_in;
         up_ff <= up_in;
         dn_ff <= dn_in;
         fl_ff <= fl_in;
         dir_ff <= dir_in;
         dst_ff <= dst_in;
         ld_ff <= ld_in;
         ul_ff <= ul_in;
         c_ff <= c_in;
         rv_ff <= rv_in;
      end
      j_ff <= j_in;
      bu_ff <= bu_in; bd_ff <= bd_in; ou_ff <= ou_in; od_ff <= od_in;
      cu_ff <= cu_in; cd_ff <= cd_in;
      sc_ff <= sc_in;
      rd_ff <= rd_in;
      rl_ff <= rl_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = rd_ff;
   assign rsp_tlast = rl_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (st_ff == S_IDLE)) else $error("ready outside idle");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled word changed");
   a_last_car: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[1:0] == CW'(CARS - 1))
      else $error("last flag on wrong car");
   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(st_ff))
      else $error("state not one-hot");
endmodule
`default_nettype wire

>>> rtl/core/mced_scan.sv
`default_nettype none
module mced_scan
   import mced_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              start,
   input  wire logic [FW-1:0]     cur,
   input  wire logic [FLOORS-1:0] dest,
   input  wire logic [FLOORS-1:0] calls,
   output logic                   done,
   output scan_type               res
);
   // Walks one floor per cycle, comparing it with the current floor.
   logic [FW:0] idx_ff, idx_in;
   logic        busy_ff, busy_in;
   scan_type    res_ff, res_in;
   logic [FW-1:0] f;

   assign f = idx_ff[FW-1:0];

   always_comb begin
      idx_in = idx_ff;
      busy_in = busy_ff;
      res_in = res_ff;
      if (start) begin
         idx_in = '0;
         busy_in = 1'b1;
         res_in = '0;
      end else if (busy_ff) begin
         if (f > cur) begin
            if (dest[f]) res_in.dest_above = 1'b1;
            if (calls[f]) begin
               if (!res_ff.req_above) res_in.near_hi = f;
               res_in.req_above = 1'b1;
               res_in.n_above = res_ff.n_above + 1'b1;
            end
         end else if (f < cur) begin
            if (dest[f]) res_in.dest_below = 1'b1;
            if (calls[f]) begin
               res_in.near_lo = f;
               res_in.req_below = 1'b1;
               res_in.n_below = res_ff.n_below + 1'b1;
            end
         end
         idx_in = idx_ff + 1'b1;
         if (idx_ff == (FW+1)'(FLOORS - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      busy_ff <= busy_in;
      res_ff <= res_in;
   end

   assign done = busy_ff && (idx_ff == (FW+1)'(FLOORS - 1));
   assign res = res_in;
endmodule
`default_nettype wire
